// ===== hdl/huffman_tree_walk_decoder_core_defines.svh =====
// ---------------------------------------------------------------------------
// Huffman tree walk decoder assertion macros
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH
`define HUFFMAN_TREE_WALK_DECODER_CORE_DEFINES_SVH

// same-cycle implication
`define HTWD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("htwd assertion failed");

// next-cycle implication
`define HTWD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("htwd assertion failed");

`endif

// ===== hdl/htwd_pkg.sv =====
// ---------------------------------------------------------------------------
// htwd_pkg
// Types and constants shared by the Huffman tree walk decoder modules.
// ---------------------------------------------------------------------------
`default_nettype none

package htwd_pkg;

  localparam int NODE_COUNT_DEF = 512;
  localparam int IDX_W          = 9;
  localparam int SYM_W          = 8;
  localparam int CNT_W          = 48;

  localparam logic [3:0] BYTE_BITS = 4'd8;
  localparam logic [2:0] MSB_POS   = 3'd7;

  localparam logic [1:0] OP_NODE    = 2'd0;
  localparam logic [1:0] OP_DATA    = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;

  localparam logic [1:0] CFG_ROOT  = 2'd0;
  localparam logic [1:0] CFG_LSB   = 2'd1;
  localparam logic [1:0] CFG_LIMIT = 2'd2;

  typedef struct packed {
    logic [1:0]       op;
    logic [IDX_W-1:0] node_addr;
    logic             node_is_leaf;
    logic [SYM_W-1:0] node_symbol;
    logic [IDX_W-1:0] left_child;
    logic [IDX_W-1:0] right_child;
    logic [1:0]       child_present;
    logic [7:0]       data_byte;
  } req_t;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             last;
    logic             bad_path;
    logic             done_res;
  } res_t;

  // table entry: [28:27] present, [26] leaf, [25:18] symbol, [17:9] left, [8:0] right
  typedef struct packed {
    logic [1:0]       present;
    logic             is_leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic clr;
    logic inc;
  } cnt_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_EVAL
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/huffman_tree_walk_decoder_core.sv =====
// ---------------------------------------------------------------------------
// huffman_tree_walk_decoder_core
// Huffman decoder walking a stored code tree one bit per node fetch.
//
//   channel  handshake                 payload
//   cmd      start & !busy             cmd (req_t)
//   result   strobe, one cycle         result (res_t)
//   config   cfg_valid & cfg_ready     cfg_index, cfg_data
//
// Node write and restart requests are handled while idle; busy stays low.
// A data byte walks up to 8 bits and decodes the symbols it completes; each
// step is one read of the node table (fetch state, then evaluate state).
// Reset is synchronous; the node table is not cleared and must be loaded.
// Config writes are taken only while idle (cfg_ready = !busy).
// The receiver cannot stall; results leave through a register.
// ---------------------------------------------------------------------------
`default_nettype none

module huffman_tree_walk_decoder_core #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire htwd_pkg::req_t              cmd,
  output logic                             busy,
  output logic                             strobe,
  output htwd_pkg::res_t                   result,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [1:0]                  cfg_index,
  input  wire logic [htwd_pkg::CNT_W-1:0]  cfg_data
);
  import htwd_pkg::*;

  localparam int AW = $clog2(NODE_COUNT);

  logic [IDX_W-1:0] root_node;
  logic             lsb_first;
  logic [CNT_W-1:0] symbol_limit;
  logic             cfg_wr;
  logic             root_load;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  node_t            ram_wdata;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  node_t            ram_rdata;
  cnt_ctl_t         cnt_ctl;
  logic             reached;

  assign cfg_ready = !busy;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign root_load = cfg_wr && (cfg_index == CFG_ROOT);

  always_ff @(posedge clk) begin
    if (rst) begin
      root_node    <= '0;
      lsb_first    <= 1'b0;
      symbol_limit <= '1;
    end else if (cfg_wr) begin
      case (cfg_index)
        CFG_ROOT:  root_node    <= cfg_data[IDX_W-1:0];
        CFG_LSB:   lsb_first    <= cfg_data[0];
        CFG_LIMIT: symbol_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  htwd_node_ram #(
    .DEPTH (NODE_COUNT),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  htwd_count_unit u_cnt (
    .clk          (clk),
    .rst          (rst),
    .ctl          (cnt_ctl),
    .symbol_limit (symbol_limit),
    .reached      (reached)
  );

  htwd_seq #(
    .NODE_COUNT (NODE_COUNT),
    .AW         (AW)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .cmd        (cmd),
    .busy       (busy),
    .root_node  (root_node),
    .root_load  (root_load),
    .root_value (cfg_data[IDX_W-1:0]),
    .lsb_first  (lsb_first),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .cnt_ctl    (cnt_ctl),
    .reached    (reached),
    .strobe     (strobe),
    .result     (result)
  );

endmodule

`default_nettype wire

// ===== hdl/htwd_node_ram.sv =====
// ---------------------------------------------------------------------------
// htwd_node_ram
// Node table: one write port, one registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module htwd_node_ram #(
  parameter int DEPTH = htwd_pkg::NODE_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire htwd_pkg::node_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output htwd_pkg::node_t      rdata
);
  import htwd_pkg::*;

  node_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/htwd_count_unit.sv =====
// ---------------------------------------------------------------------------
// htwd_count_unit
// Decoded symbol counter with the shared limit comparator.
// ---------------------------------------------------------------------------
`default_nettype none

module htwd_count_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire htwd_pkg::cnt_ctl_t            ctl,
  input  wire logic [htwd_pkg::CNT_W-1:0]    symbol_limit,
  output logic                               reached
);
  import htwd_pkg::*;

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;

  always_comb begin
    if (ctl.clr) begin
      count_next = '0;
    end else if (ctl.inc) begin
      count_next = count + CNT_W'(1);
    end else begin
      count_next = count;
    end
  end

  assign reached = (count_next >= symbol_limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/htwd_seq.sv =====
// ---------------------------------------------------------------------------
// htwd_seq
// Walk sequencer: fetches one node per step, steps on each byte bit,
// emits symbols and errors through a one-deep pending stage.
// ---------------------------------------------------------------------------
`default_nettype none
`include "huffman_tree_walk_decoder_core_defines.svh"

module htwd_seq #(
  parameter int NODE_COUNT = htwd_pkg::NODE_COUNT_DEF,
  parameter int AW         = $clog2(NODE_COUNT)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  input  wire htwd_pkg::req_t              cmd,
  output logic                             busy,
  input  wire logic [htwd_pkg::IDX_W-1:0]  root_node,
  input  wire logic                        root_load,
  input  wire logic [htwd_pkg::IDX_W-1:0]  root_value,
  input  wire logic                        lsb_first,
  output logic                             ram_we,
  output logic [AW-1:0]                    ram_waddr,
  output htwd_pkg::node_t                  ram_wdata,
  output logic                             ram_re,
  output logic [AW-1:0]                    ram_raddr,
  input  wire htwd_pkg::node_t             ram_rdata,
  output htwd_pkg::cnt_ctl_t               cnt_ctl,
  input  wire logic                        reached,
  output logic                             strobe,
  output htwd_pkg::res_t                   result
);
  import htwd_pkg::*;

  function automatic logic in_range(input logic [IDX_W-1:0] idx);
    return int'(idx) < NODE_COUNT;
  endfunction

  state_t           state, state_next;
  logic [IDX_W-1:0] cur, cur_next;
  logic             arrived, arrived_next;
  logic [3:0]       bit_cnt, bit_cnt_next;
  logic [7:0]       data_reg, data_next;
  logic             oor, oor_next;
  logic             pend_valid, pend_valid_next;
  res_t             pend, pend_next;
  logic             strobe_next;
  res_t             result_next;

  node_t            entry;
  logic [2:0]       pos;
  logic             bit_val;
  logic [IDX_W-1:0] child;
  logic             emit;
  logic             finish;
  res_t             new_res;

  assign busy      = (state != ST_IDLE);
  assign entry     = oor ? '0 : ram_rdata;
  assign pos       = lsb_first ? bit_cnt[2:0] : (MSB_POS - bit_cnt[2:0]);
  assign bit_val   = data_reg[pos];
  assign child     = bit_val ? entry.right : entry.left;
  assign ram_raddr = AW'(cur);
  assign ram_waddr = AW'(cmd.node_addr);
  assign ram_wdata = '{present: cmd.child_present, is_leaf: cmd.node_is_leaf,
                       symbol: cmd.node_symbol, left: cmd.left_child,
                       right: cmd.right_child};

  assign cnt_ctl.clr = (state == ST_IDLE) && start && (cmd.op == OP_RESTART);
  assign cnt_ctl.inc = (state == ST_EVAL) && arrived && entry.is_leaf;

  always_comb begin
    state_next      = state;
    cur_next        = cur;
    arrived_next    = arrived;
    bit_cnt_next    = bit_cnt;
    data_next       = data_reg;
    oor_next        = oor;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    strobe_next     = 1'b0;
    result_next     = result;
    ram_we          = 1'b0;
    ram_re          = 1'b0;
    emit            = 1'b0;
    finish          = 1'b0;
    new_res         = '0;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.op)
            OP_NODE: begin
              ram_we = in_range(cmd.node_addr);
            end
            OP_DATA: begin
              data_next    = cmd.data_byte;
              bit_cnt_next = '0;
              arrived_next = 1'b0;
              state_next   = ST_FETCH;
            end
            OP_RESTART: begin
              cur_next = root_node;
            end
            default: begin
            end
          endcase
        end
        if (root_load) begin
          cur_next = root_value;
        end
      end
      ST_FETCH: begin
        ram_re     = 1'b1;
        oor_next   = !in_range(cur);
        state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (arrived && entry.is_leaf) begin
          emit             = 1'b1;
          new_res.symbol   = entry.symbol;
          new_res.done_res = reached;
          cur_next         = root_node;
          arrived_next     = 1'b0;
          state_next       = ST_FETCH;
        end else if ((bit_cnt == BYTE_BITS) || reached) begin
          finish = 1'b1;
        end else begin
          bit_cnt_next = bit_cnt + 4'd1;
          state_next   = ST_FETCH;
          if (!entry.present[bit_val] || !in_range(child)) begin
            emit             = 1'b1;
            new_res.bad_path = 1'b1;
            new_res.done_res = reached;
            cur_next         = root_node;
            arrived_next     = 1'b0;
          end else begin
            cur_next     = child;
            arrived_next = 1'b1;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (emit) begin
      if (pend_valid) begin
        strobe_next      = 1'b1;
        result_next      = pend;
        result_next.last = 1'b0;
      end
      pend_next       = new_res;
      pend_valid_next = 1'b1;
    end
    if (finish) begin
      if (pend_valid) begin
        strobe_next      = 1'b1;
        result_next      = pend;
        result_next.last = 1'b1;
      end
      pend_valid_next = 1'b0;
      state_next      = ST_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur        <= '0;
      arrived    <= 1'b0;
      bit_cnt    <= '0;
      oor        <= 1'b0;
      pend_valid <= 1'b0;
      strobe     <= 1'b0;
    end else begin
      state      <= state_next;
      cur        <= cur_next;
      arrived    <= arrived_next;
      bit_cnt    <= bit_cnt_next;
      oor        <= oor_next;
      pend_valid <= pend_valid_next;
      strobe     <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    data_reg <= data_next;
    pend     <= pend_next;
    result   <= result_next;
  end

  `HTWD_ASSERT_IMPL(a_idle_no_pend, state == ST_IDLE, !pend_valid)
  `HTWD_ASSERT_IMPL(a_bit_cnt_range, busy, bit_cnt <= BYTE_BITS)
  `HTWD_ASSERT_IMPL(a_bad_zero_sym, strobe && result.bad_path, result.symbol == '0)
  `HTWD_ASSERT_NEXT(a_fetch_eval, state == ST_FETCH, state == ST_EVAL)
  `HTWD_ASSERT_NEXT(a_finish_idle, state == ST_EVAL && finish, !busy)

endmodule

`default_nettype wire

// ===== verif/huffman_tree_walk_decoder_core_tb.sv =====
// ---------------------------------------------------------------------------
// huffman_tree_walk_decoder_core_tb
// Self-checking bench for the tree walk decoder. Loads the whole node table,
// then runs directed trees (full, one-sided, childless), bit order, symbol
// limit, root moves and ignored ops, then random trees with random streams.
// A local decoder model predicts every result; a monitor compares them.
// ---------------------------------------------------------------------------
module huffman_tree_walk_decoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import htwd_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         TBL_SIZE  = 32;

  logic             clk       = 1'b0;
  logic             rst       = 1'b1;
  logic             start     = 1'b0;
  req_t             cmd       = '0;
  logic             busy;
  logic             strobe;
  res_t             result;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [1:0]       cfg_index = CFG_ROOT;
  logic [CNT_W-1:0] cfg_data  = '0;

  huffman_tree_walk_decoder_core #(
    .NODE_COUNT (TBL_SIZE)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .strobe    (strobe),
    .result    (result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // decoder model state
  node_t            node_mem [0:TBL_SIZE-1];
  logic [IDX_W-1:0] root_idx  = '0;
  logic [IDX_W-1:0] walk_node = '0;
  logic             lsb_mode  = 1'b0;
  logic [CNT_W-1:0] sym_limit = '1;
  logic [CNT_W-1:0] sym_count = '0;

  res_t expected_symbols [$];

  int errors      = 0;
  int reqs_sent   = 0;
  int bytes_sent  = 0;
  int res_checked = 0;
  int bad_seen    = 0;
  int next_gap    = 0;
  bit idle_on     = 1'b1;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("%0t timeout, %0d results still pending", $time, expected_symbols.size());
    $display("== FAIL ==");
    $finish;
  end

  // entries past the table read as an empty internal node
  function automatic node_t read_node(input logic [IDX_W-1:0] idx);
    if (int'(idx) < TBL_SIZE) return node_mem[idx];
    return '0;
  endfunction

  function automatic void predict_symbols(input req_t r);
    res_t             out [$];
    res_t             one;
    node_t            e;
    node_t            ce;
    logic [IDX_W-1:0] child;
    logic [2:0]       pos;
    logic             b;
    case (r.op)
      OP_NODE: begin
        e.present = r.child_present;
        e.is_leaf = r.node_is_leaf;
        e.symbol  = r.node_symbol;
        e.left    = r.left_child;
        e.right   = r.right_child;
        if (int'(r.node_addr) < TBL_SIZE) node_mem[r.node_addr] = e;
      end
      OP_RESTART: begin
        walk_node = root_idx;
        sym_count = '0;
      end
      OP_DATA: begin
        for (int i = 0; i < BYTE_BITS; i++) begin
          if (sym_count < sym_limit) begin
            pos   = lsb_mode ? 3'(i) : MSB_POS - 3'(i);
            b     = r.data_byte[pos];
            e     = read_node(walk_node);
            child = b ? e.right : e.left;
            if (!e.present[b] || int'(child) >= TBL_SIZE) begin
              walk_node    = root_idx;
              one.symbol   = '0;
              one.last     = 1'b0;
              one.bad_path = 1'b1;
              one.done_res = (sym_count >= sym_limit);
              out.push_back(one);
            end else begin
              walk_node = child;
              ce = read_node(child);
              if (ce.is_leaf) begin
                sym_count    = sym_count + 1'b1;
                walk_node    = root_idx;
                one.symbol   = ce.symbol;
                one.last     = 1'b0;
                one.bad_path = 1'b0;
                one.done_res = (sym_count >= sym_limit);
                out.push_back(one);
              end
            end
          end
        end
        if (out.size() > 0) out[out.size()-1].last = 1'b1;
        foreach (out[k]) expected_symbols.push_back(out[k]);
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    res_t exp_r;
    if (!rst && strobe) begin
      if (expected_symbols.size() == 0) begin
        errors++;
        $display("%0t ERROR unexpected result: got sym=%h last=%b bad=%b done=%b",
                 $time, result.symbol, result.last, result.bad_path, result.done_res);
      end else begin
        exp_r = expected_symbols.pop_front();
        res_checked++;
        if (exp_r.bad_path) bad_seen++;
        if (result.symbol !== exp_r.symbol || result.last !== exp_r.last ||
            result.bad_path !== exp_r.bad_path || result.done_res !== exp_r.done_res) begin
          errors++;
          $display("%0t ERROR sym/last/bad/done expected %h/%b/%b/%b got %h/%b/%b/%b",
                   $time, exp_r.symbol, exp_r.last, exp_r.bad_path, exp_r.done_res,
                   result.symbol, result.last, result.bad_path, result.done_res);
        end
      end
    end
  end

  task automatic send_req(input req_t r);
    if (next_gap > 0) repeat (next_gap) @(posedge clk);
    start <= 1'b1;
    cmd   <= r;
    do @(posedge clk); while (busy);
    predict_symbols(r);
    reqs_sent++;
    if (r.op == OP_DATA) bytes_sent++;
    next_gap = idle_on ? int'($urandom_range(0, 19)) : 0;
    if (next_gap > 0) start <= 1'b0;
  endtask

  task automatic hold_off();
    if (next_gap == 0) start <= 1'b0;
    next_gap = 0;
    @(posedge clk);
  endtask

  // idle the block: all results in, then room for a walk that emits nothing
  task automatic quiesce();
    hold_off();
    while (expected_symbols.size() != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [1:0] idx, input logic [CNT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_ROOT: begin
        root_idx  = val[IDX_W-1:0];
        walk_node = root_idx;
      end
      CFG_LSB:   lsb_mode  = val[0];
      CFG_LIMIT: sym_limit = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic req_t noise_req(input logic [1:0] op);
    req_t q;
    q.op            = op;
    q.node_addr     = IDX_W'($urandom);
    q.node_is_leaf  = 1'($urandom);
    q.node_symbol   = SYM_W'($urandom);
    q.left_child    = IDX_W'($urandom);
    q.right_child   = IDX_W'($urandom);
    q.child_present = 2'($urandom);
    q.data_byte     = 8'($urandom);
    return q;
  endfunction

  function automatic req_t node_req(input logic [IDX_W-1:0] addr, input logic leaf,
                                    input logic [SYM_W-1:0] sym,
                                    input logic [IDX_W-1:0] l, input logic [IDX_W-1:0] r,
                                    input logic [1:0] pres);
    req_t q;
    q               = noise_req(OP_NODE);
    q.node_addr     = addr;
    q.node_is_leaf  = leaf;
    q.node_symbol   = sym;
    q.left_child    = l;
    q.right_child   = r;
    q.child_present = pres;
    return q;
  endfunction

  function automatic req_t data_req(input logic [7:0] d);
    req_t q;
    q           = noise_req(OP_DATA);
    q.data_byte = d;
    return q;
  endfunction

  task automatic leaf_write(input logic [IDX_W-1:0] addr, input logic [SYM_W-1:0] sym);
    send_req(node_req(addr, 1'b1, sym, IDX_W'($urandom), IDX_W'($urandom), 2'($urandom)));
  endtask

  task automatic inner_write(input logic [IDX_W-1:0] addr, input logic [IDX_W-1:0] l,
                             input logic [IDX_W-1:0] r, input logic [1:0] pres);
    send_req(node_req(addr, 1'b0, SYM_W'($urandom), l, r, pres));
  endtask

  task automatic build_tree(input int leaves, output logic [IDX_W-1:0] top);
    bit               used [0:TBL_SIZE-1];
    logic [IDX_W-1:0] roots [$];
    logic [IDX_W-1:0] a;
    logic [IDX_W-1:0] b;
    logic [IDX_W-1:0] c;
    int               k;
    logic [1:0]       pres;
    foreach (used[i]) used[i] = 1'b0;
    for (int n = 0; n < leaves; n++) begin
      do c = IDX_W'($urandom_range(0, TBL_SIZE-1)); while (used[c]);
      used[c] = 1'b1;
      leaf_write(c, SYM_W'($urandom));
      roots.push_back(c);
    end
    while (roots.size() > 1) begin
      k = $urandom_range(0, roots.size()-1);
      a = roots[k];
      roots.delete(k);
      k = $urandom_range(0, roots.size()-1);
      b = roots[k];
      roots.delete(k);
      do c = IDX_W'($urandom_range(0, TBL_SIZE-1)); while (used[c]);
      used[c] = 1'b1;
      pres = ($urandom_range(0, 9) == 0) ? 2'($urandom_range(0, 2)) : 2'b11;
      inner_write(c, a, b, pres);
      roots.push_back(c);
    end
    top = roots[0];
  endtask

  // every entry gets written, so no walk ever reads an unloaded node
  task automatic test_table_load();
    idle_on = 1'b0;
    for (int a = 0; a < TBL_SIZE; a++) begin
      send_req(node_req(IDX_W'(a), 1'($urandom), SYM_W'($urandom), IDX_W'($urandom),
                        IDX_W'($urandom), 2'($urandom)));
    end
    idle_on = 1'b1;
  endtask

  // codes: 0 -> 00, 10 -> FF, 11 -> 5A; rooted at 10
  task automatic test_fixed_tree();
    inner_write(9'd10, 9'd11, 9'd12, 2'b11);
    leaf_write(9'd11, 8'h00);
    inner_write(9'd12, 9'd13, 9'd14, 2'b11);
    leaf_write(9'd13, 8'hFF);
    leaf_write(9'd14, 8'h5A);
    quiesce();
    cfg_write(CFG_ROOT, 48'd10);
    send_req(data_req(8'h00));
    send_req(data_req(8'hFF));
    send_req(data_req(8'hA5));
    quiesce();
    cfg_write(CFG_LSB, 48'd1);
    send_req(data_req(8'h06));
    send_req(data_req(8'h3C));
    quiesce();
    cfg_write(CFG_LSB, 48'd0);
  endtask

  task automatic test_missing_child();
    inner_write(9'd20, 9'd21, IDX_W'($urandom), 2'b01);
    leaf_write(9'd21, 8'h81);
    inner_write(9'd22, IDX_W'($urandom), 9'd21, 2'b10);
    inner_write(9'd23, IDX_W'($urandom), IDX_W'($urandom), 2'b00);
    quiesce();
    cfg_write(CFG_ROOT, 48'd20);
    send_req(data_req(8'h0F));
    quiesce();
    cfg_write(CFG_ROOT, 48'd22);
    send_req(data_req(8'h5A));
    quiesce();
    cfg_write(CFG_ROOT, 48'd23);
    send_req(data_req(8'hC3));
    quiesce();
    cfg_write(CFG_ROOT, 48'd10);
  endtask

  task automatic test_symbol_limit();
    cfg_write(CFG_LIMIT, 48'd3);
    send_req(noise_req(OP_RESTART));
    send_req(data_req(8'h00));
    send_req(data_req(8'hFF));
    send_req(noise_req(OP_RESTART));
    send_req(data_req(8'h00));
    quiesce();
    cfg_write(CFG_LIMIT, 48'd0);
    send_req(data_req(8'h00));
    quiesce();
    cfg_write(CFG_LIMIT, '1);
    send_req(noise_req(OP_RESTART));
  endtask

  // leave the walk inside the tree, then move the root, once past the table
  task automatic test_root_move();
    send_req(data_req(8'h01));
    quiesce();
    cfg_write(CFG_ROOT, 48'd20);
    send_req(data_req(8'h00));
    quiesce();
    cfg_write(CFG_ROOT, 48'd300);
    send_req(data_req(8'h96));
    quiesce();
    cfg_write(CFG_ROOT, 48'd10);
  endtask

  task automatic test_ignored_ops();
    send_req(data_req(8'h01));
    send_req(noise_req(OP_UNUSED));
    send_req(noise_req(OP_UNUSED));
    send_req(data_req(8'h80));
    send_req(noise_req(OP_RESTART));
    send_req(data_req(8'h7F));
  endtask

  task automatic test_random_streams();
    logic [IDX_W-1:0] top;
    logic [63:0]      wide;
    int               pick;
    for (int rnd = 0; rnd < 6; rnd++) begin
      build_tree($urandom_range(2, 16), top);
      quiesce();
      cfg_write(CFG_LSB, 48'($urandom_range(0, 1)));
      pick = $urandom_range(0, 3);
      wide = {$urandom, $urandom};
      if (pick == 0) cfg_write(CFG_LIMIT, '1);
      else if (pick == 3) cfg_write(CFG_LIMIT, wide[CNT_W-1:0]);
      else cfg_write(CFG_LIMIT, 48'($urandom_range(1, 20)));
      cfg_write(CFG_ROOT, 48'(top));
      for (int n = 0; n < 10; n++) begin
        if (n == 5) begin
          hold_off();
          while (expected_symbols.size() != 0) @(posedge clk);
        end
        pick = $urandom_range(0, 99);
        if (pick < 75) send_req(data_req(8'($urandom)));
        else if (pick < 85) send_req(noise_req(OP_RESTART));
        else if (pick < 95) send_req(noise_req(OP_NODE));
        else send_req(noise_req(OP_UNUSED));
      end
      quiesce();
    end
  endtask

  initial begin
    int drain;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_table_load();
    test_fixed_tree();
    test_missing_child();
    test_symbol_limit();
    test_root_move();
    test_ignored_ops();
    test_random_streams();
    hold_off();
    drain = 0;
    while (expected_symbols.size() != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    if (expected_symbols.size() != 0) begin
      errors += expected_symbols.size();
      $display("%0t ERROR %0d expected results never arrived", $time, expected_symbols.size());
    end
    $display("Covered %0d requests (%0d data bytes), %0d results checked, %0d bad-path.",
             reqs_sent, bytes_sent, res_checked, bad_seen);
    $display("Swept root moves, both bit orders, limits from zero to max; %0d mismatches.",
             errors);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== huffman_tree_walk_decoder_core.f =====
+incdir+hdl
hdl/htwd_pkg.sv
hdl/htwd_node_ram.sv
hdl/htwd_count_unit.sv
hdl/htwd_seq.sv
hdl/huffman_tree_walk_decoder_core.sv
verif/huffman_tree_walk_decoder_core_tb.sv
